// File: sv/dlm_pkg.sv
// Shared types, register indexes and default sizes for the delimiter split block.
// No dependencies; every other file of the block except dlm_fifo imports this package.
package dlm_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_SEPARATOR_DEF = 8;
  localparam int OFFSET_BITS_DEF   = 16;

  // Fixed field widths
  localparam int SEP_REG_BYTES = 8;
  localparam int FIELD_BITS    = 16;

  // Depth of the queues between and behind the two halves
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [1:0] REG_SEP_BYTES   = 2'd0;
  localparam logic [1:0] REG_SEP_LENGTH  = 2'd1;
  localparam logic [1:0] REG_PIECE_LIMIT = 2'd2;

  // Input word action codes
  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_EOT  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] text_byte;
  } dlm_item_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] piece_start;
    logic [FIELD_BITS-1:0] piece_length;
    logic                  piece_valid;
    logic                  last;
    logic                  overflow;
  } dlm_result_t;

  // Live configuration; sep_len is already clamped to the window depth
  typedef struct packed {
    logic [8*SEP_REG_BYTES-1:0] sep_bytes;
    logic [3:0]                 sep_len;
    logic [FIELD_BITS-1:0]      piece_limit;
  } dlm_cfg_t;

  // Classified word passed from the front half to the back half
  typedef struct packed {
    logic eot;
    logic match;
  } dlm_token_t;

endpackage

// File: sv/dlm_fifo.sv
// Small register-based first-in first-out queue, width and depth set by parameters.
// Depends on nothing; DEPTH must be a power of two of at least two.
module dlm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/dlm_front.sv
// Front half: keeps the window of recent text bytes and classifies each input word.
// Depends on dlm_pkg; feeds classified words into the token queue.
module dlm_front #(
  parameter int MAX_SEPARATOR = dlm_pkg::MAX_SEPARATOR_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dlm_pkg::dlm_cfg_t  cfg,
  input  logic               accept,
  input  dlm_pkg::dlm_item_t item,
  output logic               tok_push,
  output dlm_pkg::dlm_token_t tok_data
);
  import dlm_pkg::*;

  logic [7:0] window_r   [MAX_SEPARATOR];
  logic [7:0] window_nxt [MAX_SEPARATOR];
  logic       match;

  // Shift the new byte in at the front; clear at end of text
  always_comb begin
    for (int k = 0; k < MAX_SEPARATOR; k++) begin
      window_nxt[k] = window_r[k];
    end
    if (accept) begin
      if (item.action == ACTION_EOT) begin
        for (int k = 0; k < MAX_SEPARATOR; k++) begin
          window_nxt[k] = '0;
        end
      end else begin
        for (int k = MAX_SEPARATOR - 1; k > 0; k--) begin
          window_nxt[k] = window_r[k-1];
        end
        window_nxt[0] = item.text_byte;
      end
    end
  end

  // Compare the window against the separator; newest byte meets its last byte
  always_comb begin
    logic [2:0] sel;
    match = 1'b1;
    for (int k = 0; k < MAX_SEPARATOR; k++) begin
      sel = 3'(cfg.sep_len - 4'd1 - 4'(k));
      if ((4'(k) < cfg.sep_len) && (window_nxt[k] != cfg.sep_bytes[8*sel +: 8])) begin
        match = 1'b0;
      end
    end
  end

  assign tok_push       = accept;
  assign tok_data.eot   = (item.action == ACTION_EOT);
  assign tok_data.match = match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SEPARATOR; k++) begin
        window_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_SEPARATOR; k++) begin
        window_r[k] <= window_nxt[k];
      end
    end
  end

endmodule

// File: sv/dlm_back.sv
// Back half: tracks offsets and piece count, turns classified words into descriptors.
// Depends on dlm_pkg; pops the token queue and pushes the result queue.
module dlm_back #(
  parameter int OFFSET_BITS = dlm_pkg::OFFSET_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dlm_pkg::dlm_cfg_t   cfg,
  input  logic                tok_empty,
  input  dlm_pkg::dlm_token_t tok_head,
  output logic                tok_pop,
  input  logic                res_full,
  output logic                res_push,
  output dlm_pkg::dlm_result_t res_data
);
  import dlm_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] open_r, open_nxt;
  logic [FIELD_BITS-1:0]  pieces_r, pieces_nxt;
  logic                   limit_r, limit_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [OFFSET_BITS:0]   pos_inc;
  logic [OFFSET_BITS:0]   mstart_w;
  logic [OFFSET_BITS-1:0] pos_sat;
  logic [OFFSET_BITS-1:0] mstart;
  logic [OFFSET_BITS-1:0] span;
  logic [OFFSET_BITS-1:0] gap;
  logic [FIELD_BITS-1:0]  pieces_inc;
  logic                   len_ok;
  logic                   ovf_byte;
  logic                   count;

  // Take a word only when the result queue has room
  assign tok_pop = !tok_empty && !res_full;

  // Offset arithmetic shared by all cases
  always_comb begin
    pos_inc    = {1'b0, pos_r} + (OFFSET_BITS+1)'(1);
    pos_sat    = (pos_r == OFFSET_MAX) ? pos_r : pos_inc[OFFSET_BITS-1:0];
    mstart_w   = pos_inc - (OFFSET_BITS+1)'(cfg.sep_len);
    mstart     = mstart_w[OFFSET_BITS-1:0];
    len_ok     = (pos_inc >= (OFFSET_BITS+1)'(cfg.sep_len));
    span       = pos_r - open_r;
    gap        = mstart - open_r;
    pieces_inc = (pieces_r != '1) ? pieces_r + FIELD_BITS'(1) : pieces_r;
    ovf_byte   = ovf_r || (pos_r == OFFSET_MAX);
  end

  // Build the descriptor and next state for the word at the queue head
  always_comb begin
    pos_nxt    = pos_r;
    open_nxt   = open_r;
    pieces_nxt = pieces_r;
    limit_nxt  = limit_r;
    ovf_nxt    = ovf_r;
    res_push   = 1'b0;
    res_data   = '0;
    count      = 1'b0;
    if (tok_pop) begin
      if (tok_head.eot) begin
        res_push          = 1'b1;
        res_data.last     = 1'b1;
        res_data.overflow = ovf_r;
        priority if (pos_r == '0) begin
          res_data.piece_valid = 1'b1;
        end else if (!limit_r && (open_r < pos_r)) begin
          res_data.piece_valid  = 1'b1;
          res_data.piece_start  = FIELD_BITS'(open_r);
          res_data.piece_length = FIELD_BITS'(span);
        end else begin
          res_data.piece_valid = 1'b0;
        end
        // Drop all per-text state
        pos_nxt    = '0;
        open_nxt   = '0;
        pieces_nxt = '0;
        limit_nxt  = 1'b0;
        ovf_nxt    = 1'b0;
      end else begin
        pos_nxt           = pos_sat;
        ovf_nxt           = ovf_byte;
        res_data.overflow = ovf_byte;
        priority if (limit_r) begin
          res_push = 1'b0;
        end else if (cfg.sep_len == '0) begin
          res_push              = 1'b1;
          res_data.piece_valid  = 1'b1;
          res_data.piece_start  = FIELD_BITS'(pos_r);
          res_data.piece_length = FIELD_BITS'(1);
          open_nxt              = pos_sat;
          count                 = 1'b1;
        end else if (len_ok && (mstart >= open_r) && tok_head.match) begin
          res_push              = 1'b1;
          res_data.piece_valid  = 1'b1;
          res_data.piece_start  = FIELD_BITS'(open_r);
          res_data.piece_length = FIELD_BITS'(gap);
          open_nxt              = pos_sat;
          count                 = 1'b1;
        end else begin
          res_push = 1'b0;
        end
      end
      // Count the piece and check the limit
      if (count) begin
        pieces_nxt = pieces_inc;
        limit_nxt  = limit_r || ((cfg.piece_limit != '0) && (pieces_inc >= cfg.piece_limit));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      open_r   <= '0;
      pieces_r <= '0;
      limit_r  <= 1'b0;
      ovf_r    <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      open_r   <= open_nxt;
      pieces_r <= pieces_nxt;
      limit_r  <= limit_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

// File: sv/delimiter_split_core.sv
// Splits a byte stream at a configured separator of up to MAX_SEPARATOR bytes
// and returns one (start, length) descriptor per piece. One input word (a text
// byte or an end-of-text mark) is taken every clock while full is low; the
// separator compare over the byte window is done in the cycle of acceptance
// and offset bookkeeping once the word heads the token queue and the result
// queue has room; the result is then registered in the result queue. A
// two-entry queue between the front and back halves and a two-entry result
// queue let either side stall without stopping the other. Write configuration
// only while no words are in flight.
// Depends on dlm_pkg, dlm_fifo, dlm_front and dlm_back.
module delimiter_split_core #(
  parameter int MAX_SEPARATOR = dlm_pkg::MAX_SEPARATOR_DEF,
  parameter int OFFSET_BITS   = dlm_pkg::OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input word channel
  input  logic                 push,
  output logic                 full,
  input  dlm_pkg::dlm_item_t   in_item,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output dlm_pkg::dlm_result_t out_result,
  // configuration port
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);
  import dlm_pkg::*;

  logic [8*SEP_REG_BYTES-1:0] sep_bytes_r, sep_bytes_nxt;
  logic [3:0]                 sep_len_r, sep_len_nxt;
  logic [FIELD_BITS-1:0]      piece_limit_r, piece_limit_nxt;
  dlm_cfg_t                   cfg;

  logic        accept;
  logic        tok_push, tok_full, tok_empty, tok_pop;
  dlm_token_t  tok_data, tok_head;
  logic        res_push, res_full;
  dlm_result_t res_data;

  // Configuration writes
  always_comb begin
    sep_bytes_nxt   = sep_bytes_r;
    sep_len_nxt     = sep_len_r;
    piece_limit_nxt = piece_limit_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SEP_BYTES:   sep_bytes_nxt   = cfg_wdata;
        REG_SEP_LENGTH:  sep_len_nxt     = cfg_wdata[3:0];
        REG_PIECE_LIMIT: piece_limit_nxt = cfg_wdata[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_bytes_r   <= '0;
      sep_len_r     <= '0;
      piece_limit_r <= '0;
    end else begin
      sep_bytes_r   <= sep_bytes_nxt;
      sep_len_r     <= sep_len_nxt;
      piece_limit_r <= piece_limit_nxt;
    end
  end

  // Clamp the separator length to the window depth
  always_comb begin
    cfg.sep_bytes   = sep_bytes_r;
    cfg.sep_len     = (sep_len_r > 4'(MAX_SEPARATOR)) ? 4'(MAX_SEPARATOR) : sep_len_r;
    cfg.piece_limit = piece_limit_r;
  end

  assign accept = push && !full;
  assign full   = tok_full;

  dlm_front #(
    .MAX_SEPARATOR(MAX_SEPARATOR)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (accept),
    .item     (in_item),
    .tok_push (tok_push),
    .tok_data (tok_data)
  );

  dlm_fifo #(
    .WIDTH($bits(dlm_token_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_tok_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (tok_push),
    .wdata (tok_data),
    .full  (tok_full),
    .pop   (tok_pop),
    .rdata (tok_head),
    .empty (tok_empty)
  );

  dlm_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .tok_empty (tok_empty),
    .tok_head  (tok_head),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  dlm_fifo #(
    .WIDTH($bits(dlm_result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_result),
    .empty (empty)
  );

  // The back half never writes into a full result queue
  a_no_res_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result written while result queue full");

  // A bare end marker carries no offsets
  a_bare_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !res_data.piece_valid) |->
      (res_data.piece_start == '0) && (res_data.piece_length == '0) && res_data.last)
    else $error("bare end marker with nonzero offsets");

  // Results from text bytes are always valid pieces and never close the text
  a_byte_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !tok_head.eot) |-> (res_data.piece_valid && !res_data.last))
    else $error("text byte produced a closing or bare result");

endmodule

// File: tb/delimiter_split_core_tb.sv
// Self-checking testbench for delimiter_split_core: directed rows, then random
// texts under four flow-control phases.
// Depends on dlm_pkg and the delimiter_split_core RTL.
`timescale 1ns / 1ps

module delimiter_split_core_tb;
  import dlm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_WORDS = 290;
  localparam logic [FIELD_BITS-1:0] OFFSET_CEIL = FIELD_BITS'((1 << OFFSET_BITS_DEF) - 1);

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    dlm_item_t   word;
    logic [1:0]  reg_idx;
    logic [63:0] reg_val;
    bit          pinned;
    dlm_result_t pin;
  } dir_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  dlm_item_t   in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  dlm_result_t out_result;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_SEP_BYTES;
  logic [63:0] cfg_wdata = '0;

  // Predicted register contents
  logic [63:0]           sep_bytes_cfg = '0;
  logic [3:0]            sep_len_cfg = '0;
  logic [FIELD_BITS-1:0] limit_cfg = '0;

  // Predicted per-text state
  logic [7:0]            window [MAX_SEPARATOR_DEF];
  logic [FIELD_BITS-1:0] next_pos;
  logic [FIELD_BITS-1:0] open_start;
  logic [FIELD_BITS-1:0] piece_count;
  bit                    limit_hit;
  bit                    ovf_seen;

  dlm_result_t pending_pieces[$];
  dir_row_t    dir_rows[$];

  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int words_taken = 0;
  int pieces_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  delimiter_split_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_result(out_result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [FIELD_BITS-1:0] sat_next(input logic [FIELD_BITS-1:0] v);
    return (v == OFFSET_CEIL) ? v : v + 1'b1;
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < MAX_SEPARATOR_DEF; k++) window[k] = '0;
    next_pos = '0;
    open_start = '0;
    piece_count = '0;
    limit_hit = 1'b0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void bump_count();
    if (piece_count != '1) piece_count = piece_count + 1'b1;
    if (limit_cfg != 0 && piece_count >= limit_cfg) limit_hit = 1'b1;
  endfunction

  // Advance the text state by one word; return 1 when the word yields a piece
  function automatic bit predict_piece(input dlm_item_t w, output dlm_result_t r);
    int eff;
    int mstart;
    bit hit;
    logic [FIELD_BITS-1:0] p;
    eff = (sep_len_cfg > MAX_SEPARATOR_DEF) ? MAX_SEPARATOR_DEF : sep_len_cfg;
    r = '0;
    // close the text: remainder, empty text or bare end marker
    if (w.action == ACTION_EOT) begin
      r.last = 1'b1;
      r.overflow = ovf_seen;
      if (next_pos == 0) begin
        r.piece_valid = 1'b1;
      end else if (!limit_hit && open_start < next_pos) begin
        r.piece_start = open_start;
        r.piece_length = next_pos - open_start;
        r.piece_valid = 1'b1;
      end
      clear_text();
      return 1'b1;
    end
    // count the byte and shift it into the window
    p = next_pos;
    if (p == OFFSET_CEIL) ovf_seen = 1'b1;
    next_pos = sat_next(p);
    for (int k = MAX_SEPARATOR_DEF - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = w.text_byte;
    r.overflow = ovf_seen;
    if (limit_hit) return 1'b0;
    if (eff == 0) begin
      r.piece_start = p;
      r.piece_length = 1;
      r.piece_valid = 1'b1;
      open_start = sat_next(p);
      bump_count();
      return 1'b1;
    end
    // leftmost, non-overlapping: the match may not start inside a closed piece
    if (int'(p) + 1 >= eff) begin
      mstart = int'(p) + 1 - eff;
      hit = (mstart >= int'(open_start));
      for (int k = 0; k < eff; k++)
        if (window[k] != sep_bytes_cfg[8*(eff-1-k) +: 8]) hit = 1'b0;
      if (hit) begin
        r.piece_start = open_start;
        r.piece_length = FIELD_BITS'(mstart - int'(open_start));
        r.piece_valid = 1'b1;
        open_start = sat_next(p);
        bump_count();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one word until taken; a pinned row supplies its own expected piece
  task automatic send_word(input dlm_item_t w, input bit pinned, input dlm_result_t pin);
    bit taken;
    bit has;
    dlm_result_t r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      if ($urandom_range(0, 99) < send_idle_pct) begin
        push <= 1'b0;
      end else begin
        push <= 1'b1;
        in_item <= w;
      end
      @(posedge clk);
      taken = push && !full;
    end
    has = predict_piece(w, r);
    words_taken++;
    if (pinned) pending_pieces.push_back(pin);
    else if (has) pending_pieces.push_back(r);
  endtask

  task automatic put_byte(input logic [7:0] b);
    dlm_item_t w;
    w.action = ACTION_BYTE;
    w.text_byte = b;
    send_word(w, 1'b0, '0);
  endtask

  task automatic put_eot();
    dlm_item_t w;
    w.action = ACTION_EOT;
    w.text_byte = 8'($urandom_range(0, 255));
    send_word(w, 1'b0, '0);
  endtask

  // Hold the sender, drain every expected piece, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_pieces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_SEP_BYTES:   sep_bytes_cfg = val;
      REG_SEP_LENGTH:  sep_len_cfg = val[3:0];
      REG_PIECE_LIMIT: limit_cfg = val[FIELD_BITS-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random text built mostly from separator runs, partial separators and
  // separator bytes so that matches happen often
  task automatic run_text();
    int eff;
    int target;
    int n;
    int r;
    int part;
    eff = (sep_len_cfg > MAX_SEPARATOR_DEF) ? MAX_SEPARATOR_DEF : sep_len_cfg;
    target = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
    n = 0;
    while (n < target) begin
      r = $urandom_range(0, 99);
      if (eff > 0 && r < 35) begin
        for (int k = 0; k < eff; k++) put_byte(sep_bytes_cfg[8*k +: 8]);
        n += eff;
      end else if (eff > 1 && r < 45) begin
        part = $urandom_range(1, eff - 1);
        for (int k = 0; k < part; k++) put_byte(sep_bytes_cfg[8*k +: 8]);
        n += part;
      end else if (eff > 0 && r < 70) begin
        put_byte(sep_bytes_cfg[8*$urandom_range(0, eff - 1) +: 8]);
        n++;
      end else begin
        put_byte(8'($urandom_range(0, 255)));
        n++;
      end
    end
    put_eot();
  endtask

  task automatic random_config();
    int r;
    logic [63:0] sb;
    r = $urandom_range(0, 99);
    if (r < 5) sb = '0;
    else if (r < 10) sb = '1;
    else sb = {$urandom, $urandom};
    write_reg(REG_SEP_BYTES, sb);
    r = $urandom_range(0, 99);
    if (r < 12) write_reg(REG_SEP_LENGTH, 64'd0);
    else if (r < 20) write_reg(REG_SEP_LENGTH, 64'($urandom_range(9, 15)));
    else if (r < 35) write_reg(REG_SEP_LENGTH, 64'(MAX_SEPARATOR_DEF));
    else write_reg(REG_SEP_LENGTH, 64'($urandom_range(1, MAX_SEPARATOR_DEF)));
    r = $urandom_range(0, 99);
    if (r < 60) write_reg(REG_PIECE_LIMIT, 64'd0);
    else if (r < 90) write_reg(REG_PIECE_LIMIT, 64'($urandom_range(1, 6)));
    else if (r < 95) write_reg(REG_PIECE_LIMIT, 64'hFFFF);
    else write_reg(REG_PIECE_LIMIT, 64'($urandom_range(1, 65535)));
  endtask

  // ---------------------------------------------------------------- directed rows

  function automatic dir_row_t word_row(input logic act, input logic [7:0] b);
    dir_row_t row;
    row.kind = ROW_WORD;
    row.word.action = act;
    row.word.text_byte = b;
    row.reg_idx = REG_SEP_BYTES;
    row.reg_val = '0;
    row.pinned = 1'b0;
    row.pin = '0;
    return row;
  endfunction

  function automatic dir_row_t pin_row(input logic act, input logic [7:0] b,
                                       input int start, input int len,
                                       input bit valid, input bit last, input bit ovf);
    dir_row_t row;
    row = word_row(act, b);
    row.pinned = 1'b1;
    row.pin.piece_start = FIELD_BITS'(start);
    row.pin.piece_length = FIELD_BITS'(len);
    row.pin.piece_valid = valid;
    row.pin.last = last;
    row.pin.overflow = ovf;
    return row;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [63:0] val);
    dir_row_t row;
    row = word_row(ACTION_BYTE, 8'h00);
    row.kind = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // ---------------------------------------------------------------- checker

  task automatic check_piece(input dlm_result_t got);
    dlm_result_t want;
    if (pending_pieces.size() == 0) begin
      $error("unexpected piece: start %0d length %0d valid %0d last %0d overflow %0d",
             got.piece_start, got.piece_length, got.piece_valid, got.last, got.overflow);
      mismatches++;
      return;
    end
    want = pending_pieces.pop_front();
    if (got.piece_start !== want.piece_start) begin
      $error("piece_start: expected %0d, got %0d", want.piece_start, got.piece_start);
      mismatches++;
    end
    if (got.piece_length !== want.piece_length) begin
      $error("piece_length: expected %0d, got %0d", want.piece_length, got.piece_length);
      mismatches++;
    end
    if (got.piece_valid !== want.piece_valid) begin
      $error("piece_valid: expected %0d, got %0d", want.piece_valid, got.piece_valid);
      mismatches++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %0d, got %0d", want.last, got.last);
      mismatches++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
      mismatches++;
    end
  endtask

  // Stall the receiver at random
  always @(negedge clk) begin
    if (rst_n) pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Compare every word popped from the result side
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      check_piece(out_result);
      pieces_checked++;
    end
  end

  // End the run if no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles, %0d pieces outstanding",
               STALL_LIMIT, pending_pieces.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase_base;
    int text_count;
    clear_text();

    // empty text at reset, every byte its own piece, bare end marker
    dir_rows.push_back(pin_row(ACTION_EOT, 8'h00, 0, 0, 1, 1, 0));
    dir_rows.push_back(pin_row(ACTION_BYTE, 8'h00, 0, 1, 1, 0, 0));
    dir_rows.push_back(pin_row(ACTION_BYTE, 8'hFF, 1, 1, 1, 0, 0));
    dir_rows.push_back(pin_row(ACTION_EOT, 8'hFF, 0, 0, 0, 1, 0));
    // two-byte separator, empty pieces, text ending in a separator
    dir_rows.push_back(reg_row(REG_SEP_BYTES, 64'h202C));
    dir_rows.push_back(reg_row(REG_SEP_LENGTH, 64'd2));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h2C));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h20));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h2C));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h20));
    dir_rows.push_back(pin_row(ACTION_EOT, 8'h00, 0, 0, 0, 1, 0));
    // repeated-byte separator: overlapping matches are skipped
    dir_rows.push_back(reg_row(REG_SEP_BYTES, 64'h6161));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h61));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h61));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h61));
    dir_rows.push_back(word_row(ACTION_EOT, 8'h00));
    // piece limit of one: later bytes are dropped, end is a bare marker
    dir_rows.push_back(reg_row(REG_PIECE_LIMIT, 64'd1));
    dir_rows.push_back(reg_row(REG_SEP_LENGTH, 64'd0));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'h5A));
    dir_rows.push_back(word_row(ACTION_BYTE, 8'hA5));
    dir_rows.push_back(pin_row(ACTION_EOT, 8'h00, 0, 0, 0, 1, 0));
    // oversize length acts as the full window over an all-ones separator
    dir_rows.push_back(reg_row(REG_PIECE_LIMIT, 64'd0));
    dir_rows.push_back(reg_row(REG_SEP_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(reg_row(REG_SEP_LENGTH, 64'd15));
    for (int k = 0; k < 8; k++) dir_rows.push_back(word_row(ACTION_BYTE, 8'hFF));
    dir_rows.push_back(pin_row(ACTION_EOT, 8'h00, 0, 0, 0, 1, 0));

    // hold reset, then release it
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // walk the directed rows
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].pin);
      end
    end

    // random texts under each flow-control phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 82; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 82; end
        default: begin send_idle_pct = 9; pop_stall_pct = 9; end
      endcase
      phase_base = words_taken;
      while (words_taken - phase_base < PHASE_WORDS) begin
        settle();
        random_config();
        text_count = $urandom_range(1, 4);
        repeat (text_count) run_text();
      end
    end

    // drain and report
    settle();
    $display("Ran %0d words with %0d register writes; checked %0d pieces, %0d mismatches.",
             words_taken, reg_writes, pieces_checked, mismatches);
    $display("Covered directed cases and random texts under four idle/stall mixes.");
    if (mismatches == 0 && pending_pieces.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/dlm_pkg.sv
sv/dlm_fifo.sv
sv/dlm_front.sv
sv/dlm_back.sv
sv/delimiter_split_core.sv
tb/delimiter_split_core_tb.sv
